FILE: design/dws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distinct word set package
// Sizes, derived widths and the byte normalizer shared by the word-set files.
// ----------------------------------------------------------------------------
package dws_pkg;
    localparam int MaxWords   = 128;
    localparam int MaxWordLen = 64;
    localparam int SlotW      = $clog2(MaxWords);
    localparam int PosW       = $clog2(MaxWordLen);
    localparam int LenW       = $clog2(MaxWordLen + 1);
    localparam int CountW     = $clog2(MaxWords + 1);
    localparam int AddrW      = SlotW + PosW;

    localparam logic [7:0] CharHyphen = 8'd45;
    localparam logic [7:0] CharUpperA = 8'd65;
    localparam logic [7:0] CharLowerA = 8'd97;
    localparam logic [7:0] CharTop    = 8'd128;
    localparam logic [7:0] CaseShift  = 8'd32;

    typedef struct packed {
        logic       keep;
        logic [7:0] value;
    } t_norm;

    function automatic t_norm norm_byte(input logic [7:0] c, input logic last);
        t_norm r;
        r.keep  = 1'b1;
        r.value = c;
        if (c == CharHyphen && !last) begin
            r.value = c;
        end else if (c < CharUpperA || c >= CharTop) begin
            r.keep = 1'b0;
        end else if (c < CharLowerA) begin
            r.value = c + CaseShift;
        end
        return r;
    endfunction
endpackage

FILE: design/dws_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for input bytes and word results.
// ----------------------------------------------------------------------------
interface dws_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_of_word;
    modport source (output valid, char_code, last_of_word, input ready);
    modport sink   (input valid, char_code, last_of_word, output ready);
endinterface

interface dws_out_if;
    logic       valid;
    logic       ready;
    logic       is_new;
    logic [6:0] word_index;
    logic [7:0] distinct_count;
    logic       table_full;
    logic       word_truncated;
    modport source (output valid, is_new, word_index, distinct_count, table_full,
                    word_truncated, input ready);
    modport sink   (input valid, is_new, word_index, distinct_count, table_full,
                    word_truncated, output ready);
endinterface

FILE: design/distinct_word_set_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distinct word set unit
// A byte that is not a word end is taken and gives no result.
// A word end scans the stored words: a slot of another length is passed once
// its length is read, and one that differs once its first unequal byte is seen.
// A match ends the scan; a new word is then copied into the table, while a
// full table gives a result with no copy; the next word's bytes may flow while a result waits.
// Synchronous reset clears the count, word length and flags; memories are not cleared.
// ----------------------------------------------------------------------------
module distinct_word_set_unit
    import dws_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    dws_in_if.sink    in_ch,
    dws_out_if.source out_ch
);
    typedef enum logic [5:0] {
        S_TAKE  = 6'b000001,
        S_LEN   = 6'b000010,
        S_CMP   = 6'b000100,
        S_COPY  = 6'b001000,
        S_LAST  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state            r_state;
    logic [LenW-1:0]   r_len;
    logic              r_over;
    logic [CountW-1:0] r_count;
    logic [SlotW-1:0]  r_slot;
    logic [LenW-1:0]   r_pos;
    logic              r_scan_end;
    logic              r_ovalid;
    logic              r_new, r_full, r_trunc;
    logic [SlotW-1:0]  r_idx;
    // Result register, loaded in the done state once the previous result is taken.
    logic              r_o_new, r_o_full, r_o_trunc;
    logic [SlotW-1:0]  r_o_idx;
    logic [CountW-1:0] r_o_count;

    // Current word buffer.
    logic              cur_we;
    logic [PosW-1:0]   cur_waddr, cur_raddr;
    logic [7:0]        cur_wdata, cur_rdata;
    // Stored words and lengths.
    logic              st_we, len_we;
    logic [AddrW-1:0]  st_waddr, st_raddr;
    logic [7:0]        st_rdata;
    logic [LenW-1:0]   len_rdata;

    dws_ram #(.Width(8), .Depth(MaxWordLen)) u_cur (
        .i_clk, .i_we(cur_we), .i_waddr(cur_waddr), .i_wdata(cur_wdata),
        .i_raddr(cur_raddr), .o_rdata(cur_rdata));
    dws_ram #(.Width(8), .Depth(MaxWords * MaxWordLen)) u_chars (
        .i_clk, .i_we(st_we), .i_waddr(st_waddr), .i_wdata(cur_rdata),
        .i_raddr(st_raddr), .o_rdata(st_rdata));
    dws_ram #(.Width(LenW), .Depth(MaxWords)) u_lens (
        .i_clk, .i_we(len_we), .i_waddr(r_slot), .i_wdata(r_len),
        .i_raddr(r_slot), .o_rdata(len_rdata));

    t_norm nb;
    logic  acc;
    logic [LenW-1:0] pos_m1;
    assign nb     = norm_byte(in_ch.char_code, in_ch.last_of_word);
    assign acc    = in_ch.valid && in_ch.ready;
    assign pos_m1 = r_pos - LenW'(1);

    assign in_ch.ready = (r_state == S_TAKE);
    assign cur_we      = acc && nb.keep && (r_len < LenW'(MaxWordLen));
    assign cur_waddr   = r_len[PosW-1:0];
    assign cur_wdata   = nb.value;
    assign cur_raddr   = r_pos[PosW-1:0];
    assign st_raddr    = {r_slot, r_pos[PosW-1:0]};
    // Copy writes the byte read from the buffer in the previous cycle.
    assign st_we       = (r_state == S_COPY || r_state == S_LAST) && r_pos != '0;
    assign st_waddr    = {r_slot, pos_m1[PosW-1:0]};
    assign len_we      = (r_state == S_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_TAKE;
            r_len      <= '0;
            r_over     <= 1'b0;
            r_count    <= '0;
            r_ovalid   <= 1'b0;
            r_slot     <= '0;
            r_pos      <= '0;
            r_scan_end <= 1'b0;
            r_o_new    <= 1'b0;
            r_o_full   <= 1'b0;
            r_o_trunc  <= 1'b0;
            r_o_idx    <= '0;
            r_o_count  <= '0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_TAKE: begin
                    if (acc) begin
                        if (nb.keep) begin
                            if (r_len < LenW'(MaxWordLen)) r_len <= r_len + LenW'(1);
                            else r_over <= 1'b1;
                        end
                        if (in_ch.last_of_word) begin
                            r_trunc <= r_over ||
                                (nb.keep && r_len == LenW'(MaxWordLen));
                            r_slot     <= '0;
                            r_pos      <= '0;
                            r_scan_end <= 1'b0;
                            r_state    <= S_LEN;
                        end
                    end
                end
                S_LEN: begin
                    // Slot r_slot length is read this cycle, data next.
                    if (r_scan_end || CountW'(r_slot) >= r_count) begin
                        r_pos <= '0;
                        if (r_count < CountW'(MaxWords)) begin
                            r_new <= 1'b1; r_full <= 1'b0;
                            r_idx <= r_slot;
                            r_state <= (r_len == '0) ? S_LAST : S_COPY;
                        end else begin
                            r_new <= 1'b1; r_full <= 1'b1; r_idx <= '0;
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_pos   <= '0;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    // Reads of byte r_pos are issued; compare byte r_pos-1.
                    if (r_pos == '0 && len_rdata != r_len) begin
                        r_slot <= r_slot + SlotW'(1);
                        r_scan_end <= (CountW'(r_slot) + CountW'(1) == r_count);
                        r_state <= S_LEN;
                    end else if (r_pos != '0 && st_rdata != cur_rdata) begin
                        r_slot <= r_slot + SlotW'(1);
                        r_scan_end <= (CountW'(r_slot) + CountW'(1) == r_count);
                        r_pos <= '0;
                        r_state <= S_LEN;
                    end else if (r_pos == r_len) begin
                        r_new <= 1'b0; r_full <= 1'b0; r_idx <= r_slot;
                        r_state <= S_DONE;
                    end else begin
                        r_pos <= r_pos + LenW'(1);
                    end
                end
                S_COPY: begin
                    r_pos <= r_pos + LenW'(1);
                    if (r_pos + LenW'(1) == r_len) r_state <= S_LAST;
                end
                S_LAST: begin
                    r_count <= r_count + CountW'(1);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid) begin
                        r_ovalid  <= 1'b1;
                        r_o_new   <= r_new;
                        r_o_full  <= r_full;
                        r_o_trunc <= r_trunc;
                        r_o_idx   <= r_idx;
                        r_o_count <= r_count;
                        r_len     <= '0;
                        r_over    <= 1'b0;
                        r_state   <= S_TAKE;
                    end
                end
                default: r_state <= S_TAKE;
            endcase
        end
    end

    assign out_ch.valid          = r_ovalid;
    assign out_ch.is_new         = r_o_new;
    assign out_ch.word_index     = 7'(r_o_idx);
    assign out_ch.distinct_count = 8'(r_o_count);
    assign out_ch.table_full     = r_o_full;
    assign out_ch.word_truncated = r_o_trunc;
endmodule

FILE: design/dws_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dws_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: design/dws_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word set checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dws_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       o_ready,
    input logic       o_is_new,
    input logic       o_full,
    input logic [7:0] o_count,
    input logic [6:0] o_index
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ready |=> o_valid && $stable(o_count))
        else $error("result dropped while stalled");
    a_full_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_full |-> o_is_new && o_index == 7'd0)
        else $error("full result must be new at index zero");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_count <= 8'd128)
        else $error("count above table size");
    a_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_new |-> {1'b0, o_index} < o_count)
        else $error("found index outside stored words");
endmodule

bind distinct_word_set_unit dws_checker u_dws_checker (
    .i_clk, .i_rst_n,
    .o_valid(out_ch.valid), .o_ready(out_ch.ready), .o_is_new(out_ch.is_new),
    .o_full(out_ch.table_full), .o_count(out_ch.distinct_count),
    .o_index(out_ch.word_index));

FILE: sim/distinct_word_set_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distinct word set testbench
// Streams token bytes into the word-set unit and checks each word result
// against a behavioral model of normalization, lookup and table growth.
// ----------------------------------------------------------------------------
module distinct_word_set_unit_tb;
    import dws_pkg::*;

    typedef struct packed {
        logic       is_new;
        logic [6:0] word_index;
        logic [7:0] distinct_count;
        logic       table_full;
        logic       word_truncated;
    } t_word_result;

    typedef struct {
        logic [7:0] c;
        logic       last;
        logic       known;
        t_word_result res;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    dws_in_if  in_ch ();
    dws_out_if out_ch ();

    distinct_word_set_unit uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Model state of the word table.
    logic [7:0] word_bytes [MaxWords][MaxWordLen];
    int         word_len   [MaxWords];
    int         words_held;
    logic [7:0] token_bytes [MaxWordLen];
    int         token_len;
    logic       token_overlong;

    t_word_result pending_results [$];
    t_word_result typed_results   [$];
    logic         typed_known     [$];
    int  failures;
    int  words_checked;
    int  bytes_sent;

    // Returns 1 and fills res when the byte closes a word.
    function automatic bit predict_byte(input logic [7:0] c, input logic last,
                                        output t_word_result res);
        logic [7:0] v;
        bit keep;
        bit found;
        int idx;
        keep = 1;
        v = c;
        found = 0;
        idx = 0;
        res = '0;
        if (c == 8'd45 && !last) begin
            v = c;
        end else if (c < 8'd65 || c >= 8'd128) begin
            keep = 0;
        end else if (c < 8'd97) begin
            v = c + 8'd32;
        end
        if (keep) begin
            if (token_len < MaxWordLen) begin
                token_bytes[token_len] = v;
                token_len++;
            end else begin
                token_overlong = 1;
            end
        end
        if (!last) return 0;
        for (int s = 0; s < words_held && !found; s++) begin
            if (word_len[s] == token_len) begin
                found = 1;
                for (int k = 0; k < token_len; k++)
                    if (word_bytes[s][k] != token_bytes[k]) found = 0;
                if (found) idx = s;
            end
        end
        if (!found) begin
            if (words_held < MaxWords) begin
                idx = words_held;
                for (int k = 0; k < token_len; k++) word_bytes[idx][k] = token_bytes[k];
                word_len[idx] = token_len;
                words_held++;
            end else begin
                res.table_full = 1;
                idx = 0;
            end
        end
        res.is_new         = !found;
        res.word_index     = idx[6:0];
        res.distinct_count = words_held[7:0];
        res.word_truncated = token_overlong;
        token_len = 0;
        token_overlong = 0;
        return 1;
    endfunction

    initial i_clk = 0;
    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    initial begin
        #50_000_000;
        $display("status: fail");
        $finish;
    end

    // Receiver stalls on a slowly changing random pattern.
    int stall_mode;
    initial begin
        out_ch.ready = 0;
        stall_mode = 0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: out_ch.ready <= 1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                default: out_ch.ready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_word_result got;
        t_word_result want;
        t_word_result typed;
        logic known;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.is_new         = out_ch.is_new;
            got.word_index     = out_ch.word_index;
            got.distinct_count = out_ch.distinct_count;
            got.table_full     = out_ch.table_full;
            got.word_truncated = out_ch.word_truncated;
            if (pending_results.size() == 0) begin
                $error("unexpected word result %p", got);
                failures++;
            end else begin
                want  = pending_results.pop_front();
                typed = typed_results.pop_front();
                known = typed_known.pop_front();
                if (known && typed != want) begin
                    $error("typed-in result %p disagrees with model %p", typed, want);
                    failures++;
                end
                if (got.is_new != want.is_new) begin
                    $error("is_new: expected %0d, got %0d", want.is_new, got.is_new);
                    failures++;
                end
                if (got.word_index != want.word_index) begin
                    $error("word_index: expected %0d, got %0d",
                           want.word_index, got.word_index);
                    failures++;
                end
                if (got.distinct_count != want.distinct_count) begin
                    $error("distinct_count: expected %0d, got %0d",
                           want.distinct_count, got.distinct_count);
                    failures++;
                end
                if (got.table_full != want.table_full) begin
                    $error("table_full: expected %0d, got %0d",
                           want.table_full, got.table_full);
                    failures++;
                end
                if (got.word_truncated != want.word_truncated) begin
                    $error("word_truncated: expected %0d, got %0d",
                           want.word_truncated, got.word_truncated);
                    failures++;
                end
                words_checked++;
            end
        end
    end

    int burst_left;

    // Drives one byte with burst/gap pacing and waits for its transfer.
    task automatic send_byte(input logic [7:0] c, input logic last,
                             input logic known, input t_word_result typed);
        t_word_result res;
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_ch.valid <= 0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        in_ch.valid        <= 1;
        in_ch.char_code    <= c;
        in_ch.last_of_word <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (predict_byte(c, last, res)) begin
            pending_results.push_back(res);
            typed_results.push_back(typed);
            typed_known.push_back(known);
        end
        bytes_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_word(input string w);
        for (int k = 0; k < w.len(); k++)
            send_byte(w[k], k == w.len() - 1, 1'b0, '0);
    endtask

    // Directed table: byte, last flag, whether the result is typed in, result.
    t_stim_row directed [] = '{
        '{8'h41, 1'b1, 1'b1, '{1'b1, 7'd0, 8'd1, 1'b0, 1'b0}},  // "A" -> "a", new
        '{8'h61, 1'b1, 1'b1, '{1'b0, 7'd0, 8'd1, 1'b0, 1'b0}},  // "a" found
        '{8'h00, 1'b1, 1'b1, '{1'b1, 7'd1, 8'd2, 1'b0, 1'b0}},  // empty word
        '{8'hFF, 1'b1, 1'b1, '{1'b0, 7'd1, 8'd2, 1'b0, 1'b0}},  // empty again
        '{8'h2D, 1'b1, 1'b1, '{1'b0, 7'd1, 8'd2, 1'b0, 1'b0}},  // trailing hyphen
        '{8'h5A, 1'b0, 1'b0, '0},
        '{8'h2D, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'h7F, 1'b1, 1'b1, '{1'b1, 7'd2, 8'd3, 1'b0, 1'b0}},  // "z-" + DEL
        '{8'h40, 1'b0, 1'b0, '0},
        '{8'h60, 1'b0, 1'b0, '0},
        '{8'h5B, 1'b1, 1'b0, '0},
        '{8'h7B, 1'b1, 1'b0, '0}
    };

    int n_words;
    int vocab_n;
    string vocab [16];
    string w;

    initial begin
        failures = 0;
        words_checked = 0;
        bytes_sent = 0;
        burst_left = 0;
        words_held = 0;
        token_len = 0;
        token_overlong = 0;
        i_rst_n = 0;
        in_ch.valid = 0;
        in_ch.char_code = '0;
        in_ch.last_of_word = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        foreach (directed[r])
            send_byte(directed[r].c, directed[r].last, directed[r].known,
                      directed[r].res);
        // Overlong word: 70 bytes cycling through 'A'..'z'.
        for (int k = 0; k < 70; k++) send_byte(8'(8'h41 + k % 58), k == 69, 1'b0, '0);
        send_byte(8'hC3, 1'b1, 1'b0, '0);

        // Random part: half of the words from a small vocabulary so repeats hit.
        vocab_n = 12;
        for (int v = 0; v < vocab_n; v++) begin
            vocab[v] = "";
            for (int k = 0; k < $urandom_range(1, 6); k++)
                vocab[v] = {vocab[v], string'(8'($urandom_range(8'h41, 8'h7F)))};
        end
        n_words = 0;
        while (bytes_sent < 200) begin
            case ($urandom_range(0, 5))
                0, 1, 2: send_word(vocab[$urandom_range(0, vocab_n - 1)]);
                3: begin
                    w = "";
                    for (int k = 0; k < $urandom_range(1, 5); k++)
                        w = {w, string'(8'($urandom_range(0, 255)))};
                    if (w.len() == 0) w = "-";
                    send_word(w);
                end
                default: begin
                    w = "";
                    for (int k = 0; k < $urandom_range(1, 4); k++)
                        w = {w, string'(8'($urandom_range(8'h61, 8'h7A)))};
                    send_word(w);
                end
            endcase
            n_words++;
        end
        // Fill the table with two-letter words, then offer words it has no room for.
        for (int n = 0; words_held < MaxWords; n++) begin
            send_byte(8'(8'h61 + n % 26), 1'b0, 1'b0, '0);
            send_byte(8'(8'h61 + (n / 26) % 26), 1'b1, 1'b0, '0);
        end
        for (int n = 0; n < 8; n++) begin
            send_byte(8'h51, 1'b0, 1'b0, '0);
            send_byte(8'h7A, 1'b0, 1'b0, '0);
            send_byte(8'(8'h61 + n), 1'b1, 1'b0, '0);
        end
        send_word("a");
        in_ch.valid <= 0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d bytes in %0d random words; checked %0d word results, table held %0d words.",
                 bytes_sent, n_words, words_checked, words_held);
        $display("Covered case folding, dropped bytes, hyphens, empty, overlong and full table.");
        if (failures == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

FILE: files.f
design/dws_pkg.sv
design/dws_stream_if.sv
design/dws_ram.sv
design/distinct_word_set_unit.sv
design/dws_checker.sv
sim/distinct_word_set_unit_tb.sv
